### rtl/core/hff_pkg.sv
// Shared types, constants and helpers for the hexadecimal field formatter.
// Used by the front classifier, the descriptor queue and the back sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hff_pkg;

   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned COUNT_W   = 6;
   localparam int unsigned LEN_W     = 4;
   localparam int unsigned NIBBLES   = 8;
   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 40;

   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

   // One classified conversion: how many of each kind of character to send.
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [LEN_W-1:0]   digits;
      logic [COUNT_W-1:0] zeros;
      logic [COUNT_W-1:0] spaces;
      logic               left_justify;
      logic               upper_case;
   } desc_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nibble,
                                                   input logic       upper);
      logic [CHAR_W-1:0] result;
      if (nibble < 4'd10) begin
         result = CHAR_ZERO + {4'd0, nibble};
      end else if (upper) begin
         result = CHAR_UPPER_A + {4'd0, nibble} - 8'd10;
      end else begin
         result = CHAR_LOWER_A + {4'd0, nibble} - 8'd10;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

### rtl/core/hff_front.sv
// Front classifier: unpacks one request and works out the digit, zero and
// space counts of its field. Depends on hff_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hff_front #(
   parameter int MAX_FIELD = 63
) (
   input  wire logic [47:0]      req_tdata,
   output hff_pkg::desc_type     desc
);

   logic [31:0] value;
   logic [5:0]  field_width;
   logic [6:0]  digit_precision;
   logic        zero_pad;
   logic        left_justify;
   logic        upper_case;

   logic        has_prec;
   logic [5:0]  width_sat;
   logic [5:0]  prec_sat;
   logic [3:0]  sig_len;
   logic [3:0]  len;
   logic [6:0]  len_w;
   logic [6:0]  zeros;
   logic [6:0]  used;

   assign value           = req_tdata[31:0];
   assign field_width     = req_tdata[37:32];
   assign digit_precision = req_tdata[44:38];
   assign zero_pad        = req_tdata[45];
   assign left_justify    = req_tdata[46];
   assign upper_case      = req_tdata[47];

   // A negative precision means none was given.
   assign has_prec  = !digit_precision[6];
   assign width_sat = (32'(field_width) > 32'(MAX_FIELD)) ? 6'(MAX_FIELD) : field_width;
   assign prec_sat  = (32'(digit_precision[5:0]) > 32'(MAX_FIELD)) ? 6'(MAX_FIELD)
                                                                   : digit_precision[5:0];

   always_comb begin
      sig_len = 4'd1;
      for (int i = 0; i < hff_pkg::NIBBLES; i++) begin
         if (value[i*4 +: 4] != 4'd0) begin
            sig_len = 4'(i + 1);
         end
      end
   end

   always_comb begin
      len = sig_len;
      if (has_prec && prec_sat == 6'd0 && value == 32'd0) begin
         len = 4'd0;
      end
      len_w = {3'd0, len};
      zeros = 7'd0;
      if (has_prec) begin
         if ({1'b0, prec_sat} > len_w) begin
            zeros = {1'b0, prec_sat} - len_w;
         end
      end else if (zero_pad && !left_justify && {1'b0, width_sat} > len_w) begin
         zeros = {1'b0, width_sat} - len_w;
      end
      used = len_w + zeros;

      desc.value        = value;
      desc.digits       = len;
      desc.zeros        = zeros[5:0];
      desc.spaces       = ({1'b0, width_sat} > used) ? 6'({1'b0, width_sat} - used) : 6'd0;
      desc.left_justify = left_justify;
      desc.upper_case   = upper_case;
   end

endmodule

`default_nettype wire

### rtl/core/hff_queue.sv
// Two-entry descriptor queue between the front classifier and the back
// sequencer, so that either side may stall alone. Depends on hff_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hff_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire hff_pkg::desc_type push_desc,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output hff_pkg::desc_type      pop_desc
);

   hff_pkg::desc_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_desc   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

`default_nettype wire

### rtl/core/hff_back.sv
// Back sequencer: walks one classified conversion a character per cycle,
// while the output side takes them, into a registered output stage and
// keeps the running character count. Depends on hff_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hff_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire hff_pkg::desc_type pop_desc,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [39:0]            rsp_tdata,
   output logic                   rsp_tlast
);

   typedef enum logic {
      IDLE,
      RUN
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] value_ff, value_in;
   logic [3:0]  digits_ff, digits_in;
   logic [5:0]  zeros_ff, zeros_in;
   logic [5:0]  spaces_ff, spaces_in;
   logic [5:0]  remain_ff, remain_in;
   logic        left_ff, left_in;
   logic        upper_ff, upper_in;
   logic [31:0] count_ff, count_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_char_ff, out_char_in;
   logic        out_last_ff, out_last_in;
   logic [31:0] out_total_ff, out_total_in;

   logic        advance;
   logic [6:0]  desc_total;
   logic [2:0]  nib_idx;
   logic [7:0]  next_char;

   assign advance    = !out_valid_ff || rsp_tready;
   assign pop_ready  = (state_ff == IDLE);
   assign desc_total = {3'd0, pop_desc.digits} + {1'b0, pop_desc.zeros}
                       + {1'b0, pop_desc.spaces};
   assign nib_idx    = 3'(digits_ff - 4'd1);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_total_ff, out_char_ff};
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      digits_in    = digits_ff;
      zeros_in     = zeros_ff;
      spaces_in    = spaces_ff;
      remain_in    = remain_ff;
      left_in      = left_ff;
      upper_in     = upper_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_total_in = out_total_ff;
      next_char    = hff_pkg::CHAR_SPACE;

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         IDLE: begin
            // A conversion with nothing to print is dropped here.
            if (pop_valid) begin
               value_in  = pop_desc.value;
               digits_in = pop_desc.digits;
               zeros_in  = pop_desc.zeros;
               spaces_in = pop_desc.spaces;
               left_in   = pop_desc.left_justify;
               upper_in  = pop_desc.upper_case;
               remain_in = desc_total[5:0];
               if (desc_total != 7'd0) begin
                  state_in = RUN;
               end
            end
         end
         RUN: begin
            if (advance) begin
               if (!left_ff && spaces_ff != 6'd0) begin
                  next_char = hff_pkg::CHAR_SPACE;
                  spaces_in = spaces_ff - 6'd1;
               end else if (zeros_ff != 6'd0) begin
                  next_char = hff_pkg::CHAR_ZERO;
                  zeros_in  = zeros_ff - 6'd1;
               end else if (digits_ff != 4'd0) begin
                  next_char = hff_pkg::hex_char(value_ff[nib_idx*4 +: 4], upper_ff);
                  digits_in = digits_ff - 4'd1;
               end else begin
                  next_char = hff_pkg::CHAR_SPACE;
                  spaces_in = spaces_ff - 6'd1;
               end
               count_in     = count_ff + 32'd1;
               out_valid_in = 1'b1;
               out_char_in  = next_char;
               out_last_in  = (remain_ff == 6'd1);
               out_total_in = count_ff + 32'd1;
               remain_in    = remain_ff - 6'd1;
               if (remain_ff == 6'd1) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      value_ff     <= value_in;
      digits_ff    <= digits_in;
      zeros_ff     <= zeros_in;
      spaces_ff    <= spaces_in;
      remain_ff    <= remain_in;
      left_ff      <= left_in;
      upper_ff     <= upper_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      out_total_ff <= out_total_in;
   end

endmodule

`default_nettype wire

### rtl/core/hex_field_formatter.sv
// Printf-style hexadecimal field formatter, one ASCII character per output
// transfer. Top level; instantiates hff_front, hff_queue and hff_back.
//
// Each request carries a 32-bit value and its field options; the block sends
// padding spaces, leading zeros and digits as a run of characters with tlast
// on the final one, and a running count of all characters sent. Characters
// leave at one per cycle while the output side takes them. The back
// sequencer takes the next descriptor only after it has produced the last
// character of the current one; a conversion that prints nothing is dropped.
// A two-entry queue lets requests be taken while a conversion is still being
// sent. Width and precision saturate at MAX_FIELD.
`timescale 1ns / 1ps
`default_nettype none

module hex_field_formatter #(
   parameter int MAX_FIELD = 63
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [31:0] value, [37:32] field_width, [44:38] digit_precision,
   // [45] zero_pad, [46] left_justify, [47] upper_case
   input  wire logic [47:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] character, [39:8] total_emitted
   output logic [39:0]      rsp_tdata,
   output logic             rsp_tlast
);

   hff_pkg::desc_type front_desc;
   hff_pkg::desc_type pop_desc;
   logic              pop_valid;
   logic              pop_ready;

   hff_front #(
      .MAX_FIELD (MAX_FIELD)
   ) u_front (
      .req_tdata (req_tdata),
      .desc      (front_desc)
   );

   hff_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_desc  (front_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   hff_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
